@@ rtl/fdsa_pkg.sv @@
package fdsa_pkg;

    localparam int MAX_CELLS = 4096;
    localparam int SEEN_W    = $clog2(MAX_CELLS + 1);
    localparam int IDX_W     = 12;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    // boundary modes
    localparam logic [1:0] BND_ZERO     = 2'd0;
    localparam logic [1:0] BND_NEUMANN  = 2'd1;
    localparam logic [1:0] BND_PERIODIC = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_BOUNDARY = 3'd0;
    localparam logic [2:0] CFG_INV_DX   = 3'd1;
    localparam logic [2:0] CFG_DT       = 3'd2;
    localparam logic [2:0] CFG_INV_DT   = 3'd3;
    localparam logic [2:0] CFG_INV_RHO  = 3'd4;

    // neighbor source for a stencil job
    typedef enum logic [1:0] {
        t_nb_cell  = 2'd0,  // a real cell carried in the job
        t_nb_ghost = 2'd1   // boundary ghost built from the own cell
    } t_nb_sel;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] lv;
        logic signed [31:0] lp;
        logic signed [31:0] cv;
        logic signed [31:0] cp;
        logic signed [31:0] rv;
        logic signed [31:0] rp;
        t_nb_sel            lsel;
        t_nb_sel            rsel;
        logic               last;
    } t_job;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] inv_dx;
        logic signed [31:0] dt;
        logic signed [31:0] inv_dt;
        logic signed [31:0] inv_rho;
    } t_cfg;

    // round(a*b / 2^k) ties away from zero, saturated to 32 bits
    function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] prod,
                                                   input logic k17);
        logic        neg;
        logic [65:0] mag;
        logic [65:0] q;
        begin
            neg = prod[65];
            mag = neg ? 66'(-prod) : 66'(prod);
            if (k17) q = (mag + 66'(1 << 16)) >> 17;
            else     q = (mag + 66'(1 << 15)) >> 16;
            if (neg) begin
                if (q > 66'h80000000) rnd_sat = 32'sh80000000;
                else                  rnd_sat = 32'(-q);
            end else begin
                if (q > 66'h7FFFFFFF) rnd_sat = 32'sh7FFFFFFF;
                else                  rnd_sat = 32'(q);
            end
        end
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
        begin
            if (x > 34'sh7FFFFFFF)       sat34 = 32'sh7FFFFFFF;
            else if (x < -34'sh80000000) sat34 = 32'sh80000000;
            else                         sat34 = x[31:0];
        end
    endfunction

endpackage

@@ rtl/fdsa_front.sv @@
module fdsa_front
    import fdsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_cell_velocity,
    input  logic signed [31:0] i_cell_pressure,
    input  logic               i_grid_end,
    input  logic [1:0]         i_mode,
    output logic               o_push,
    output t_job               o_job,
    input  logic [QPTR_W:0]    i_q_free
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [SEEN_W-1:0]  r_seen;
    logic signed [31:0] r_lv, r_lp, r_mv, r_mp, r_fv, r_fp, r_sv, r_sp;
    // captured transaction
    logic signed [31:0] r_cv, r_cp;
    logic               r_last;
    logic [SEEN_W-1:0]  r_n;
    logic signed [31:0] r_ov, r_op;   // old middle
    logic signed [31:0] r_olv, r_olp; // old left
    logic [1:0]         r_k;          // jobs already pushed for this transaction

    logic               per;
    logic               acc;
    logic [1:0]         njobs;
    logic [IDX_W-1:0]   idx_prev, idx_n;
    t_job               job;

    assign per  = (i_mode == BND_PERIODIC);
    assign acc  = i_valid && !o_stall;
    // needs room for three jobs so a transaction never blocks halfway
    assign o_stall = (r_state != ST_IDLE) || (i_q_free < (QPTR_W+1)'(3));

    assign idx_prev = (r_n - 1'b1 > SEEN_W'(4095)) ? IDX_W'(4095) : IDX_W'(r_n - 1'b1);
    assign idx_n    = (r_n > SEEN_W'(4095)) ? IDX_W'(4095) : IDX_W'(r_n);

    // list of jobs for the captured transaction
    always_comb begin
        njobs = 2'd0;
        if (r_n == '0) njobs = r_last ? 2'd1 : 2'd0;
        else begin
            njobs = ((r_n == SEEN_W'(1)) && per) ? 2'd0 : 2'd1;
            if (r_last) njobs = njobs + (per ? 2'd2 : 2'd1);
        end
    end

    always_comb begin
        job      = '0;
        job.lsel = t_nb_cell;
        job.rsel = t_nb_cell;
        if (r_n == '0) begin
            job.idx = '0;
            job.cv = r_cv; job.cp = r_cp;
            job.lv = r_cv; job.lp = r_cp; job.rv = r_cv; job.rp = r_cp;
            job.lsel = per ? t_nb_cell : t_nb_ghost;
            job.rsel = per ? t_nb_cell : t_nb_ghost;
        end else begin
            logic [1:0] slot;
            slot = r_k + (((r_n == SEEN_W'(1)) && per) ? 2'd1 : 2'd0);
            case (slot)
                2'd0: begin
                    job.cv = r_ov; job.cp = r_op; job.rv = r_cv; job.rp = r_cp;
                    if (r_n == SEEN_W'(1)) begin
                        job.idx = '0; job.lsel = t_nb_ghost;
                    end else begin
                        job.idx = idx_prev; job.lv = r_olv; job.lp = r_olp;
                    end
                end
                2'd1: begin
                    job.idx = idx_n;
                    job.lv = r_ov; job.lp = r_op; job.cv = r_cv; job.cp = r_cp;
                    job.rv = r_fv; job.rp = r_fp;
                    job.rsel = per ? t_nb_cell : t_nb_ghost;
                end
                default: begin
                    job.idx = '0;
                    job.lv = r_cv; job.lp = r_cp; job.cv = r_fv; job.cp = r_fp;
                    job.rv = r_sv; job.rp = r_sp;
                end
            endcase
        end
        job.last = (r_k + 2'd1 == njobs);
    end

    assign o_push = (r_state == ST_EMIT) && (njobs != 2'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seen  <= '0;
            r_k     <= '0;
            r_lv <= '0; r_lp <= '0; r_mv <= '0; r_mp <= '0;
            r_fv <= '0; r_fp <= '0; r_sv <= '0; r_sp <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_cv <= i_cell_velocity; r_cp <= i_cell_pressure;
                        r_last <= i_grid_end; r_n <= r_seen;
                        r_ov <= r_mv; r_op <= r_mp; r_olv <= r_lv; r_olp <= r_lp;
                        r_k <= '0;
                        if (r_seen == '0) begin
                            r_fv <= i_cell_velocity; r_fp <= i_cell_pressure;
                        end else begin
                            if (r_seen == SEEN_W'(1)) begin
                                r_sv <= i_cell_velocity; r_sp <= i_cell_pressure;
                            end
                            r_lv <= r_mv; r_lp <= r_mp;
                        end
                        r_mv <= i_cell_velocity; r_mp <= i_cell_pressure;
                        if (i_grid_end) r_seen <= '0;
                        else if (r_seen < SEEN_W'(MAX_CELLS)) r_seen <= r_seen + 1'b1;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (njobs == 2'd0 || r_k + 2'd1 >= njobs) r_state <= ST_IDLE;
                    else r_k <= r_k + 2'd1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/fdsa_queue.sv @@
module fdsa_queue
    import fdsa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_job            i_job,
    input  logic            i_pop,
    output logic            o_valid,
    output t_job            o_job,
    output logic [QPTR_W:0] o_free
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_free  = (QPTR_W+1)'(QDEPTH) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

@@ rtl/fdsa_back.sv @@
module fdsa_back
    import fdsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_job               i_job,
    output logic               o_pop,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_cell_index,
    output logic signed [31:0] o_pressure_gradient,
    output logic signed [31:0] o_velocity_gradient,
    output logic signed [31:0] o_velocity_curvature,
    output logic signed [31:0] o_advected_pressure,
    output logic signed [31:0] o_advected_velocity,
    output logic signed [31:0] o_momentum_rhs,
    output logic               o_run_end
);

    // one shared multiplier, one product per cycle in states ST_PG to ST_MB
    typedef enum logic [3:0] {
        ST_IDLE, ST_PG, ST_VG, ST_H2, ST_CU, ST_DV, ST_AP, ST_AV,
        ST_MA, ST_MB, ST_OUT
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic signed [32:0] r_dp, r_dv;
    logic signed [33:0] r_dd;
    logic signed [31:0] r_pg, r_vg, r_h2, r_cu, r_dvq, r_ap, r_av, r_ma, r_mr;

    logic signed [31:0] lv, lp, rv, rp;
    logic signed [32:0] ma;
    logic signed [33:0] mb;
    logic               k17;
    logic signed [66:0] prodw;
    logic signed [31:0] q;

    assign o_pop = (r_state == ST_IDLE) && i_valid;

    // ghost neighbors per boundary mode
    always_comb begin
        lv = i_job.lv; lp = i_job.lp; rv = i_job.rv; rp = i_job.rp;
        if (i_job.lsel == t_nb_ghost) begin
            lv = '0; lp = (i_cfg.mode == BND_NEUMANN) ? i_job.cp : '0;
        end
        if (i_job.rsel == t_nb_ghost) begin
            rv = '0; rp = (i_cfg.mode == BND_NEUMANN) ? i_job.cp : '0;
        end
    end

    // multiplier operand selection
    always_comb begin
        ma = '0; mb = '0; k17 = 1'b0;
        case (r_state)
            ST_PG: begin ma = r_dp; mb = 34'(i_cfg.inv_dx); k17 = 1'b1; end
            ST_VG: begin ma = r_dv; mb = 34'(i_cfg.inv_dx); k17 = 1'b1; end
            ST_H2: begin ma = 33'(i_cfg.inv_dx); mb = 34'(i_cfg.inv_dx); end
            ST_CU: begin ma = 33'(r_h2); mb = r_dd; end
            ST_DV: begin ma = 33'(i_cfg.dt); mb = 34'(r_job.cv); end
            ST_AP: begin ma = 33'(r_dvq); mb = 34'(r_pg); end
            ST_AV: begin ma = 33'(r_dvq); mb = 34'(r_vg); end
            ST_MA: begin ma = 33'(r_job.cv); mb = 34'(i_cfg.inv_dt); end
            ST_MB: begin ma = 33'(i_cfg.inv_rho); mb = 34'(r_pg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prodw = 67'(ma) * 67'(mb);
    assign q     = rnd_sat(prodw[65:0], k17);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_dp  <= 33'(rp) - 33'(lp);
                        r_dv  <= 33'(rv) - 33'(lv);
                        r_dd  <= 34'(lv) + 34'(rv) - (34'(i_job.cv) <<< 1);
                        r_state <= ST_PG;
                    end
                end
                ST_PG: begin r_pg  <= q; r_state <= ST_VG; end
                ST_VG: begin r_vg  <= q; r_state <= ST_H2; end
                ST_H2: begin r_h2  <= q; r_state <= ST_CU; end
                ST_CU: begin r_cu  <= q; r_state <= ST_DV; end
                ST_DV: begin r_dvq <= q; r_state <= ST_AP; end
                ST_AP: begin
                    r_ap <= sat34(34'(r_job.cp) - 34'(q)); r_state <= ST_AV;
                end
                ST_AV: begin
                    r_av <= sat34(34'(r_job.cv) - 34'(q)); r_state <= ST_MA;
                end
                ST_MA: begin r_ma <= q; r_state <= ST_MB; end
                ST_MB: begin
                    r_mr <= sat34(34'(r_ma) - 34'(q)); r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // output register: load when empty or being taken
                    if (!o_valid || !i_stall) begin
                        o_valid              <= 1'b1;
                        o_cell_index         <= r_job.idx;
                        o_pressure_gradient  <= r_pg;
                        o_velocity_gradient  <= r_vg;
                        o_velocity_curvature <= r_cu;
                        o_advected_pressure  <= r_ap;
                        o_advected_velocity  <= r_av;
                        o_momentum_rhs       <= r_mr;
                        o_run_end            <= r_job.last;
                        r_state              <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (o_valid && !i_stall && !(r_state == ST_OUT)) o_valid <= 1'b0;
        end
    end

endmodule

@@ rtl/fd_stencil_1d_advection.sv @@
// 1D central-difference stencil with advection terms.
// Input channel: i_valid / o_stall carry one grid cell per transaction
// (velocity, pressure in Q16.16, grid_end on the final cell). Cells of a
// grid arrive in order; a new grid starts after grid_end.
// Output channel: o_valid / i_stall carry one result per transaction; a
// cell yields zero, one, two or three results and run_end marks the last.
// Configuration: i_cfg_we / i_cfg_addr / i_cfg_data, written while idle.
// Path: the front end turns an accepted cell into jobs in the queue; the
// back end pops a job when idle, runs it through states PG to MB and OUT.
// The back end runs nine products through one shared 33x34 multiplier and
// takes no new job until the current result enters the output register.
// A four-entry job queue sits between the two ends; the front end stalls
// the input when fewer than three slots are free.
// Reset (synchronous, active low) empties the queue and window, sets
// Neumann mode and all Q16.16 factors to one.
// When the receiver stalls, the output register holds its result, the
// back end waits, the queue fills and the input then stalls in turn.
module fd_stencil_1d_advection
    import fdsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_cell_velocity,
    input  logic signed [31:0] i_cell_pressure,
    input  logic               i_grid_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_cell_index,
    output logic signed [31:0] o_pressure_gradient,
    output logic signed [31:0] o_velocity_gradient,
    output logic signed [31:0] o_velocity_curvature,
    output logic signed [31:0] o_advected_pressure,
    output logic signed [31:0] o_advected_velocity,
    output logic signed [31:0] o_momentum_rhs,
    output logic               o_run_end,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data
);

    t_cfg            r_cfg;
    logic            push, pop, q_valid;
    t_job            push_job, q_job;
    logic [QPTR_W:0] q_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= BND_NEUMANN;
            r_cfg.inv_dx  <= 32'sd65536;
            r_cfg.dt      <= 32'sd65536;
            r_cfg.inv_dt  <= 32'sd65536;
            r_cfg.inv_rho <= 32'sd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BOUNDARY: r_cfg.mode    <= i_cfg_data[1:0];
                CFG_INV_DX:   r_cfg.inv_dx  <= i_cfg_data;
                CFG_DT:       r_cfg.dt      <= i_cfg_data;
                CFG_INV_DT:   r_cfg.inv_dt  <= i_cfg_data;
                CFG_INV_RHO:  r_cfg.inv_rho <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fdsa_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_cell_velocity, .i_cell_pressure, .i_grid_end,
        .i_mode   (r_cfg.mode),
        .o_push   (push),
        .o_job    (push_job),
        .i_q_free (q_free)
    );

    fdsa_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_free  (q_free)
    );

    fdsa_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .i_cfg   (r_cfg),
        .o_valid, .i_stall,
        .o_cell_index, .o_pressure_gradient, .o_velocity_gradient,
        .o_velocity_curvature, .o_advected_pressure, .o_advected_velocity,
        .o_momentum_rhs, .o_run_end
    );

`ifndef SYNTHESIS
    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_free != '0)) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid) else $error("job queue underflow");
    // held result keeps its index while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cell_index)))
        else $error("stalled result changed");
`endif

endmodule
